[sv/pabp_pkg.sv]
// Package for the per-address token bucket policer: codes, command and status types.
package pabp_pkg;

   // Default number of buckets in the cell row.
   localparam int DEF_ENTRIES = 64;

   // Field widths.
   localparam int ADDR_W   = 32;
   localparam int TOK_W    = 24;
   localparam int TIME_W   = 32;
   localparam int LIMIT_W  = 16;
   localparam int EVICT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Register reset values.
   localparam logic [TOK_W-1:0]   BURST_RESET  = 24'd25600;
   localparam logic [TOK_W-1:0]   REFILL_RESET = 24'd2560;
   localparam logic [LIMIT_W-1:0] IDLE_RESET   = 16'd300;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BURST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REFILL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE   = 2'd2;

   // Input item kinds.
   localparam logic FUNC_CONSUME = 1'b0;
   localparam logic FUNC_TICK    = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_GRANT = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DENY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_TICK  = 2'd3;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_PICK,
      S_UPDATE,
      S_RESP
   } state_type;

   // Operation broadcast to every cell.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOOK,
      OP_PICK,
      OP_CONSUME,
      OP_TICK
   } cell_op_type;

   // Command broadcast along the cell row.
   typedef struct packed {
      cell_op_type          op;
      logic [ADDR_W-1:0]    addr;
      logic [TOK_W-1:0]     amount;
      logic [TIME_W-1:0]    now;
      logic [TIME_W-1:0]    now_next;
      logic [TOK_W-1:0]     burst;
      logic [TOK_W-1:0]     refill;
      logic [LIMIT_W-1:0]   idle_limit;
      logic                 hit_any;
   } cell_cmd_type;

   // Status reported by one cell.
   typedef struct packed {
      logic                 hit;
      logic                 evict;
      logic                 claim;
      logic                 sel;
      logic                 deny;
      logic [TOK_W-1:0]     tokens;
   } cell_stat_type;

endpackage

[sv/pabp_cell.sv]
// One bucket cell of the policer row: holds one entry and takes part in the claim chain.
module pabp_cell
   import pabp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  logic          free_in,
   output logic          free_out,
   output cell_stat_type stat
);

   logic               valid_ff, valid_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [TOK_W-1:0]   tokens_ff, tokens_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic               hit_ff, hit_in;
   logic               evict_ff, evict_in;
   logic               claim_ff, claim_in;
   logic               sel_ff, sel_in;
   logic               deny_ff, deny_in;

   logic [TIME_W-1:0]  idle_time;
   logic [TOK_W-1:0]   base;
   logic [TOK_W:0]     level;
   logic               sel_now;
   logic               deny_now;

   // The free mark ripples from the lowest cell upwards.
   assign free_out = free_in | ~valid_ff;

   // Local arithmetic of this entry.
   always_comb begin
      idle_time = cmd.now_next - last_ff;
      base      = valid_ff ? tokens_ff : cmd.burst;
      deny_now  = (base < cmd.amount);
      level     = {1'b0, tokens_ff} + {1'b0, cmd.refill};
      sel_now   = hit_ff | (claim_ff & ~cmd.hit_any);
   end

   // Next state of the entry and of its lookup flags.
   always_comb begin
      valid_in  = valid_ff;
      addr_in   = addr_ff;
      tokens_in = tokens_ff;
      last_in   = last_ff;
      hit_in    = hit_ff;
      evict_in  = evict_ff;
      claim_in  = claim_ff;
      sel_in    = sel_ff;
      deny_in   = deny_ff;
      case (cmd.op)
         OP_LOOK: begin
            hit_in   = valid_ff && (addr_ff == cmd.addr);
            evict_in = valid_ff && (idle_time > {{(TIME_W-LIMIT_W){1'b0}}, cmd.idle_limit});
         end
         OP_PICK: begin
            claim_in = ~valid_ff & ~free_in;
         end
         OP_CONSUME: begin
            sel_in  = sel_now;
            deny_in = sel_now & deny_now;
            if (sel_now) begin
               valid_in  = 1'b1;
               addr_in   = cmd.addr;
               last_in   = cmd.now;
               tokens_in = deny_now ? base : base - cmd.amount;
            end
         end
         OP_TICK: begin
            sel_in  = 1'b0;
            deny_in = 1'b0;
            if (valid_ff) begin
               if (evict_ff) begin
                  valid_in = 1'b0;
               end else if (level > {1'b0, cmd.burst}) begin
                  tokens_in = cmd.burst;
               end else begin
                  tokens_in = level[TOK_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control flags are cleared at reset; the entry payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
         evict_ff <= 1'b0;
         claim_ff <= 1'b0;
         sel_ff   <= 1'b0;
         deny_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
         evict_ff <= evict_in;
         claim_ff <= claim_in;
         sel_ff   <= sel_in;
         deny_ff  <= deny_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      tokens_ff <= tokens_in;
      last_ff   <= last_in;
   end

   // Status towards the sequencer; the level is shown only by the selected cell.
   always_comb begin
      stat.hit    = hit_ff;
      stat.evict  = evict_ff;
      stat.claim  = claim_ff;
      stat.sel    = sel_ff;
      stat.deny   = deny_ff;
      stat.tokens = sel_ff ? tokens_ff : '0;
   end

endmodule

[sv/per_address_token_bucket_policer.sv]
// Top level of the per-address token bucket policer: sequencer, registers and cell row.
//
// Input items arrive on the req_ stream: req_tuser selects a consume request (0) or a
// one-second tick (1); req_tdata carries the IPv4 address and the requested amount.
// Every item yields exactly one result item on the rsp_ stream: rsp_tuser holds the
// status (granted, denied, table full, tick done) and rsp_tdata the bucket level and
// the number of entries freed by a tick.
// Each bucket lives in a cell of a row of ENTRIES cells. An item is handled in four
// steps across the whole row: address compare and idleness test, the free-entry claim
// chain that rippled from cell to cell, the entry update, and the result load. The
// result goes into the output register at the result load, and the next item is
// accepted only after that load, so the block handles one item at a time.
// The output register holds a result while the receiver stalls; the next item may be
// accepted meanwhile, and its result waits for the register to empty.
// Reset empties the table, clears the second counter and restores the register
// defaults. csr_we writes csr_wdata to register csr_index; the user may write only while
// the block is idle, which the block does not enforce. An index past the last one is ignored.
module per_address_token_bucket_policer
   import pabp_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Input items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,  // ip_addr[31:0], amount[55:32]
   input  logic                  req_tuser,  // func[0]
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // tokens_left[23:0], evicted_count[30:24]
   output logic [STATUS_W-1:0]   rsp_tuser,  // status[1:0]
   // Configuration writes.
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   state_type            state_ff, state_in;

   logic [TOK_W-1:0]     burst_ff;
   logic [TOK_W-1:0]     refill_ff;
   logic [LIMIT_W-1:0]   idle_ff;
   logic [TIME_W-1:0]    now_ff;

   logic                 func_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [TOK_W-1:0]     amount_ff;
   logic [CNT_W-1:0]     evicted_ff, evicted_in;
   logic                 full_ff;

   logic                 rsp_valid_ff;
   logic [TOK_W-1:0]     rsp_tokens_ff;
   logic [EVICT_W-1:0]   rsp_evicted_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   cell_op_type          cmd_op;
   cell_cmd_type         cmd;
   cell_stat_type        stat [ENTRIES];
   logic [ENTRIES:0]     free_chain;
   logic [ENTRIES-1:0]   hit_vec;
   logic [ENTRIES-1:0]   evict_vec;
   logic [ENTRIES-1:0]   claim_vec;
   logic [ENTRIES-1:0]   sel_vec;
   logic [ENTRIES-1:0]   deny_vec;
   logic [TOK_W-1:0]     tokens_or;
   logic                 hit_any;
   logic                 accept;
   logic                 rsp_load;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_load   = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and the operation broadcast to the cells.
   always_comb begin
      state_in = state_ff;
      cmd_op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd_op   = OP_LOOK;
            state_in = S_PICK;
         end
         S_PICK: begin
            cmd_op   = OP_PICK;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd_op   = (func_ff == FUNC_TICK) ? OP_TICK : OP_CONSUME;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Broadcast payload of the command.
   always_comb begin
      cmd.op         = cmd_op;
      cmd.addr       = addr_ff;
      cmd.amount     = amount_ff;
      cmd.now        = now_ff;
      cmd.now_next   = now_ff + 1'b1;
      cmd.burst      = burst_ff;
      cmd.refill     = refill_ff;
      cmd.idle_limit = idle_ff;
      cmd.hit_any    = hit_any;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         burst_ff  <= BURST_RESET;
         refill_ff <= REFILL_RESET;
         idle_ff   <= IDLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BURST:  burst_ff  <= csr_wdata[TOK_W-1:0];
            CSR_REFILL: refill_ff <= csr_wdata[TOK_W-1:0];
            CSR_IDLE:   idle_ff   <= csr_wdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Second counter advances when a tick updates the row.
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0;
      end else if (cmd.op == OP_TICK) begin
         now_ff <= now_ff + 1'b1;
      end
   end

   // Item capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req_tuser;
         addr_ff   <= req_tdata[31:0];
         amount_ff <= req_tdata[55:32];
      end
   end

   // The row of bucket cells with the free-entry claim chain.
   assign free_chain[0] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      pabp_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .free_in  (free_chain[i]),
         .free_out (free_chain[i+1]),
         .stat     (stat[i])
      );
      assign hit_vec[i]   = stat[i].hit;
      assign evict_vec[i] = stat[i].evict;
      assign claim_vec[i] = stat[i].claim;
      assign sel_vec[i]   = stat[i].sel;
      assign deny_vec[i]  = stat[i].deny;
   end

   assign hit_any = |hit_vec;

   // Level of the selected cell; unselected cells show zero.
   always_comb begin
      tokens_or = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         tokens_or = tokens_or | stat[i].tokens;
      end
   end

   // Count of entries found idle during the lookup step.
   always_comb begin
      evicted_in = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         evicted_in = evicted_in + CNT_W'(evict_vec[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_PICK) begin
         evicted_ff <= evicted_in;
      end
      if (state_ff == S_UPDATE) begin
         full_ff <= !hit_any && !free_chain[ENTRIES];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (func_ff == FUNC_TICK) begin
            rsp_status_ff  <= ST_TICK;
            rsp_tokens_ff  <= '0;
            rsp_evicted_ff <= EVICT_W'(evicted_ff);
         end else begin
            rsp_tokens_ff  <= tokens_or;
            rsp_evicted_ff <= '0;
            if (full_ff) begin
               rsp_status_ff <= ST_FULL;
            end else if (|deny_vec) begin
               rsp_status_ff <= ST_DENY;
            end else begin
               rsp_status_ff <= ST_GRANT;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_evicted_ff, rsp_tokens_ff};

   // A stored address matches at most one entry.
   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one entry matches the address");

   // The claim chain picks at most one free entry.
   a_claim_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(claim_vec))
      else $error("more than one free entry claimed");

   // At most one cell is updated by a consume.
   a_sel_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel_vec))
      else $error("more than one cell selected");

   // A table-full result never comes with an updated cell.
   a_full_no_sel: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && func_ff == FUNC_CONSUME && full_ff) |-> (sel_vec == '0))
      else $error("cell updated although the table is full");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the per-address token bucket policer: bucket ledger and stimulus.

import pabp_pkg::*;

// One expected result item.
typedef struct packed {
   logic [STATUS_W-1:0] status;
   logic [TOK_W-1:0]    tokens_left;
   logic [EVICT_W-1:0]  evicted_count;
} verdict_type;

// Mirror of the bucket table: works out each verdict and holds those still owed.
class bucket_ledger;
   logic [TOK_W-1:0]   burst_max  = BURST_RESET;
   logic [TOK_W-1:0]   refill     = REFILL_RESET;
   logic [LIMIT_W-1:0] idle_limit = IDLE_RESET;

   bit                 entry_used  [DEF_ENTRIES];
   logic [ADDR_W-1:0]  entry_addr  [DEF_ENTRIES];
   logic [TOK_W-1:0]   entry_level [DEF_ENTRIES];
   logic [TIME_W-1:0]  entry_stamp [DEF_ENTRIES];
   logic [TIME_W-1:0]  seconds = '0;

   verdict_type owed_verdicts [$];
   int          failures = 0;

   // Register writes; an index beyond the last register changes nothing.
   function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_BURST:  burst_max = value;
         CSR_REFILL: refill = value;
         CSR_IDLE:   idle_limit = value[LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // Apply one accepted item to the mirror and queue the verdict it must produce.
   function void admit_item(logic func, logic [ADDR_W-1:0] addr, logic [TOK_W-1:0] amount);
      verdict_type       v;
      int                slot;
      int                i;
      logic [TOK_W:0]    level;
      logic [TIME_W-1:0] idleness;
      v = '0;
      if (func == FUNC_TICK) begin
         // Advance the clock, free stale entries and refill the rest up to capacity.
         seconds = seconds + 32'd1;
         v.status = ST_TICK;
         for (i = 0; i < DEF_ENTRIES; i++) begin
            if (entry_used[i]) begin
               idleness = seconds - entry_stamp[i];
               if (idleness > {16'b0, idle_limit}) begin
                  entry_used[i] = 1'b0;
                  v.evicted_count = v.evicted_count + 7'd1;
               end else begin
                  level = {1'b0, entry_level[i]} + {1'b0, refill};
                  if (level > {1'b0, burst_max}) level = {1'b0, burst_max};
                  entry_level[i] = level[TOK_W-1:0];
               end
            end
         end
      end else begin
         // A matching entry wins; otherwise the lowest free entry is filled to capacity.
         slot = -1;
         for (i = 0; i < DEF_ENTRIES; i++) begin
            if (slot < 0 && entry_used[i] && entry_addr[i] == addr) slot = i;
         end
         if (slot < 0) begin
            for (i = 0; i < DEF_ENTRIES; i++) begin
               if (slot < 0 && !entry_used[i]) begin
                  slot = i;
                  entry_used[i] = 1'b1;
                  entry_addr[i] = addr;
                  entry_level[i] = burst_max;
               end
            end
         end
         if (slot < 0) begin
            v.status = ST_FULL;
         end else begin
            entry_stamp[slot] = seconds;
            if (entry_level[slot] < amount) begin
               v.status = ST_DENY;
            end else begin
               entry_level[slot] = entry_level[slot] - amount;
               v.status = ST_GRANT;
            end
            v.tokens_left = entry_level[slot];
         end
      end
      owed_verdicts.push_back(v);
   endfunction

   // Compare one accepted result item with the oldest verdict owed.
   function void match_result(logic [STATUS_W-1:0] status, logic [TOK_W-1:0] tokens,
                              logic [EVICT_W-1:0] evicted);
      verdict_type v;
      if (owed_verdicts.size() == 0) begin
         $error("result item arrived with no request outstanding");
         failures++;
      end else begin
         v = owed_verdicts.pop_front();
         if (status !== v.status) begin
            $error("status: expected %0d, got %0d", v.status, status);
            failures++;
         end
         if (tokens !== v.tokens_left) begin
            $error("tokens_left: expected %0d, got %0d", v.tokens_left, tokens);
            failures++;
         end
         if (evicted !== v.evicted_count) begin
            $error("evicted_count: expected %0d, got %0d", v.evicted_count, evicted);
            failures++;
         end
      end
   endfunction

   function int owed();
      return owed_verdicts.size();
   endfunction
endclass

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 25;
   localparam int FLOOD_ITEMS = 70;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata = '0;  // ip_addr[31:0], amount[55:32]
   logic                  req_tuser = 1'b0;  // func[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;  // tokens_left[23:0], evicted_count[30:24]
   logic [STATUS_W-1:0]   rsp_tuser;  // status[1:0]
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int send_pace = 0;
   int recv_pace = 0;
   int cycle_count = 0;

   bucket_ledger ledger = new;

   per_address_token_bucket_policer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Length of an idle stretch: pace 0 never idles, higher paces idle more and longer.
   function automatic int pause_len(int pace);
      int roll;
      roll = int'($urandom_range(0, 99));
      if (pace == 0) return 0;
      if (pace == 1) begin
         if (roll < 70) return 0;
         if (roll < 95) return int'($urandom_range(1, 3));
         return int'($urandom_range(10, 40));
      end
      if (roll < 40) return 0;
      if (roll < 85) return int'($urandom_range(1, 4));
      return int'($urandom_range(10, 40));
   endfunction

   // Offer one item, starting at a falling edge, and return at the falling edge after it
   // was taken. Valid stays high between back-to-back items.
   task automatic send_item(input logic func, input logic [ADDR_W-1:0] addr,
                            input logic [TOK_W-1:0] amount);
      int gap;
      gap = pause_len(send_pace);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         req_tdata = {24'($urandom), 32'($urandom)};
         req_tuser = 1'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = func;
      req_tdata = {amount, addr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ledger.admit_item(func, addr, amount);
      @(negedge clock);
   endtask

   // Drop valid and wait until every owed result has arrived and the block has drained.
   task automatic settle();
      req_tvalid = 1'b0;
      while (ledger.owed() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      ledger.set_register(idx, value);
   endtask

   // Result side: ready is chosen at each falling edge, stalls of random length.
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         hold = pause_len(recv_pace);
         if (hold == 0) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = 1'b0;
            repeat (hold - 1) @(negedge clock);
         end
      end
   end

   // Every result item is checked at the edge that accepts it.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            ledger.match_result(rsp_tuser, rsp_tdata[TOK_W-1:0], rsp_tdata[TOK_W +: EVICT_W]);
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   initial begin
      int                kind;
      int                n;
      int                roll;
      logic [ADDR_W-1:0] pool [6];
      logic [ADDR_W-1:0] addr;
      logic [TOK_W-1:0]  amount;
      logic [TOK_W-1:0]  cap;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, register defaults: allocation, zero and full-scale amounts,
      // grant down to empty, denial, tick refill.
      send_pace = 0;
      recv_pace = 1;
      send_item(FUNC_CONSUME, 32'h0000_0000, 24'd0);
      send_item(FUNC_CONSUME, 32'hFFFF_FFFF, 24'hFF_FFFF);
      send_item(FUNC_CONSUME, 32'h0000_0000, 24'd25600);
      send_item(FUNC_CONSUME, 32'h0000_0000, 24'd1);
      send_item(FUNC_CONSUME, 32'hFFFF_FFFF, 24'd25600);
      send_item(FUNC_TICK, 32'h0000_0000, 24'd0);
      send_item(FUNC_CONSUME, 32'h0000_0000, 24'd2560);
      send_item(FUNC_CONSUME, 32'h8000_0001, 24'h80_0000);
      send_item(FUNC_TICK, 32'($urandom), 24'($urandom));

      // Capacity lowered below the stored levels: a consume spends the old level,
      // the next tick clips it to the new capacity.
      settle();
      write_reg(CSR_BURST, 24'd100);
      write_reg(CSR_REFILL, 24'd0);
      write_reg(CSR_SPARE, 24'($urandom));
      send_item(FUNC_CONSUME, 32'h8000_0001, 24'd1000);
      send_item(FUNC_CONSUME, 32'h0000_0000, 24'd0);
      send_item(FUNC_TICK, 32'($urandom), 24'($urandom));
      send_item(FUNC_CONSUME, 32'h0000_0000, 24'd0);
      send_item(FUNC_CONSUME, 32'h8000_0001, 24'd101);

      // Zero idle limit: the next tick frees everything, then the lowest entry is reused.
      settle();
      write_reg(CSR_IDLE, {8'($urandom), 16'd0});
      send_item(FUNC_TICK, 32'($urandom), 24'($urandom));
      send_item(FUNC_CONSUME, 32'h1234_5678, 24'd50);
      send_item(FUNC_CONSUME, 32'h1234_5678, 24'd50);

      // Random phases, each under its own register setting and idling pattern.
      for (int p = 0; p < PHASES; p++) begin
         settle();
         kind = p % 6;
         case (kind)
            0: begin
               write_reg(CSR_BURST, 24'($urandom_range(256, 40000)));
               write_reg(CSR_REFILL, 24'($urandom_range(0, 5000)));
               write_reg(CSR_IDLE, {8'($urandom), 16'($urandom_range(1, 4))});
            end
            1: begin
               write_reg(CSR_BURST, 24'hFF_FFFF);
               write_reg(CSR_REFILL, 24'hFF_FFFF);
               write_reg(CSR_IDLE, {8'($urandom), 16'hFFFF});
            end
            2: begin
               write_reg(CSR_BURST, 24'd0);
               write_reg(CSR_REFILL, 24'd0);
               write_reg(CSR_IDLE, 24'd0);
            end
            3: begin
               write_reg(CSR_BURST, 24'($urandom));
               write_reg(CSR_REFILL, 24'($urandom));
               write_reg(CSR_IDLE, {8'($urandom), 16'd1});
            end
            4: begin
               write_reg(CSR_BURST, 24'($urandom_range(0, 3000)));
               write_reg(CSR_REFILL, 24'($urandom_range(0, 300)));
               write_reg(CSR_IDLE, 24'd0);
            end
            default: begin
               write_reg(CSR_BURST, 24'd300);
               write_reg(CSR_REFILL, 24'd1);
               write_reg(CSR_IDLE, {8'($urandom), 16'd3});
            end
         endcase
         write_reg(CSR_SPARE, 24'($urandom));
         send_pace = int'($urandom_range(0, 2));
         recv_pace = int'($urandom_range(0, 2));
         cap = ledger.burst_max;

         if (kind == 4) begin
            // Flood the table with new addresses until it reports full, then a tick
            // empties it completely.
            for (int k = 0; k < FLOOD_ITEMS; k++)
               send_item(FUNC_CONSUME, 32'($urandom), 24'($urandom_range(0, int'(cap))));
            send_item(FUNC_TICK, 32'($urandom), 24'($urandom));
            for (int k = 0; k < 5; k++)
               send_item(FUNC_CONSUME, 32'($urandom), 24'($urandom_range(0, int'(cap))));
         end else begin
            // A small set of busy addresses, with some newcomers and regular ticks.
            for (int j = 0; j < 6; j++) pool[j] = 32'($urandom);
            for (n = 0; n < PHASE_ITEMS; n++) begin
               roll = int'($urandom_range(0, 99));
               if (roll < 15) begin
                  send_item(FUNC_TICK, 32'($urandom), 24'($urandom));
               end else begin
                  if (roll < 85) addr = pool[$urandom_range(0, 5)];
                  else addr = 32'($urandom);
                  case ($urandom_range(0, 9))
                     0:       amount = 24'd0;
                     1:       amount = 24'hFF_FFFF;
                     2, 3, 4, 5: amount = 24'($urandom_range(0, int'(cap) / 4));
                     6, 7:    amount = 24'($urandom_range(0, int'(cap)));
                     default: amount = 24'($urandom);
                  endcase
                  send_item(FUNC_CONSUME, addr, amount);
               end
            end
         end
      end

      // Drain and report.
      req_tvalid = 1'b0;
      while (ledger.owed() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (ledger.failures == 0 && ledger.owed() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[filelist.f]
sv/pabp_pkg.sv
sv/pabp_cell.sv
sv/per_address_token_bucket_policer.sv
dv/testbench.sv
